@@ rtl/snti_pkg.sv @@
// ---------------------------------------------------------------------------
// snti_pkg
// Shared types, codes and fixed-point helpers for the sigmoid neuron.
// ---------------------------------------------------------------------------
package snti_pkg;

  localparam int MAX_INPUTS_DEF   = 16;
  localparam int SIG_ENTRIES_DEF  = 256;
  localparam int ONE_Q12          = 4096;
  localparam int QDEPTH           = 2;

  // opcodes
  localparam logic [1:0] OP_INFER  = 2'd0;
  localparam logic [1:0] OP_OTRAIN = 2'd1;
  localparam logic [1:0] OP_HTRAIN = 2'd2;
  localparam logic [1:0] OP_LOAD   = 2'd3;

  // register indexes
  localparam logic REG_LR = 1'b0;
  localparam logic REG_IC = 1'b1;

  typedef struct packed {
    logic [12:0] lr;
    logic [4:0]  ic;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic               is_load;
    logic               is_infer;
    logic signed [15:0] x;
    logic [4:0]         widx;
    logic [12:0]        a_c;   // actual output clamped to one
    logic signed [16:0] err;   // e - a or e
  } item_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic ovf16(input logic signed [47:0] v);
    return (v > 48'sd32767) || (v < -48'sd32768);
  endfunction

endpackage

@@ rtl/sigmoid_neuron_train_infer.sv @@
// ---------------------------------------------------------------------------
// sigmoid_neuron_train_infer
// Single sigmoid neuron: inference and delta-rule training in Q4.12.
// ---------------------------------------------------------------------------
// Usage:
//  Input words arrive on s_t*; s_tuser holds the opcode (infer, train as
//  output, train as hidden, load weight). One word per vector element; the
//  result word leaves on m_t* after the last element of a vector only.
//  Load words write one weight and give no result.
//  APB port: learning_rate at 0x0, input_count at 0x4; write only while idle.
// Back end (one shared multiplier): load writes its weight from idle; an infer
//  element reads, multiplies and accumulates, plus the bias read at the first
//  element and the sigmoid lookup and interpolation at the last; a training
//  element updates its weight, plus delta at the first and the bias update at
//  the last. The result is registered into the output after its last step.
// A two-word queue sits between the decoding front and the back end, so input
// keeps flowing while the back end works; the output register holds a result
// while m_tready is low, and the back end waits on the next result only.
// Reset: weights read as zero, learning_rate 410, input_count 16, vector
// position back to the first element, queue and output emptied.
// ---------------------------------------------------------------------------
module sigmoid_neuron_train_infer #(
  parameter int MAX_INPUTS      = snti_pkg::MAX_INPUTS_DEF,
  parameter int SIGMOID_ENTRIES = snti_pkg::SIG_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] element_value, [20:16] weight_index, [33:21] actual_output,
  // [49:34] error_term, [55:50] zero
  input  logic [55:0] s_tdata,
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] result_value
  output logic [1:0]  m_tuser,   // [0] result_kind, [1] saturated
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import snti_pkg::*;

  cfg_t               cfg;
  logic               q_valid;
  logic               q_pop;
  item_t              q_item;
  logic signed [15:0] out_value;
  logic               out_kind;
  logic               out_sat;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register file: word index from paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lr <= 13'd410;
      cfg.ic <= 5'd16;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LR:  cfg.lr <= pwdata[12:0];
        REG_IC:  cfg.ic <= pwdata[4:0];
        default: cfg.lr <= cfg.lr;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LR:  prdata = {19'b0, cfg.lr};
      REG_IC:  prdata = {27'b0, cfg.ic};
      default: prdata = 32'b0;
    endcase
  end

  // front: decode and queue
  snti_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .opcode        (s_tuser),
    .element_value (s_tdata[15:0]),
    .weight_index  (s_tdata[20:16]),
    .act_level     (s_tdata[33:21]),
    .error_term    (s_tdata[49:34]),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // back: arithmetic sequencer and weight store
  snti_back #(
    .MAX_INPUTS      (MAX_INPUTS),
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_kind  (out_kind),
    .out_sat   (out_sat)
  );

  assign m_tdata = out_value;
  assign m_tuser = {out_sat, out_kind};

endmodule

@@ rtl/snti_front.sv @@
// ---------------------------------------------------------------------------
// snti_front
// Takes input words, decodes the opcode, queues them for the back end.
// ---------------------------------------------------------------------------
module snti_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic signed [15:0]   element_value,
  input  logic [4:0]           weight_index,
  input  logic [12:0]          act_level,
  input  logic signed [15:0]   error_term,
  output logic                 q_valid,
  output snti_pkg::item_t      q_item,
  input  logic                 q_pop
);
  import snti_pkg::*;

  item_t      q_mem [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;
  logic [12:0] a_c;

  always_comb begin
    a_c = (act_level > 13'(ONE_Q12)) ? 13'(ONE_Q12) : act_level;
    cls.is_load  = (opcode == OP_LOAD);
    cls.is_infer = (opcode == OP_INFER);
    cls.x        = element_value;
    cls.widx     = weight_index;
    cls.a_c      = a_c;
    if (opcode == OP_OTRAIN) begin
      cls.err = 17'(error_term) - $signed({4'b0, a_c});
    end else begin
      cls.err = 17'(error_term);
    end
  end

  assign in_ready = (count != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= cls;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'(QDEPTH))
    else $error("queue count over depth");

endmodule

@@ rtl/snti_back.sv @@
// ---------------------------------------------------------------------------
// snti_back
// Sequencer over one shared multiplier: dot product, sigmoid, delta rule.
// ---------------------------------------------------------------------------
module snti_back #(
  parameter int MAX_INPUTS      = snti_pkg::MAX_INPUTS_DEF,
  parameter int SIGMOID_ENTRIES = snti_pkg::SIG_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  snti_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  input  snti_pkg::item_t      q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_value,
  output logic                 out_kind,
  output logic                 out_sat
);
  import snti_pkg::*;

  localparam int IW = $clog2(MAX_INPUTS + 1);
  localparam int TW = $clog2(SIGMOID_ENTRIES + 1);
  localparam int UW = 16 + TW;

  // table step 8/E in Q30
  localparam logic [63:0] G_Q30 = (64'd8 << 30) / 64'(SIGMOID_ENTRIES);

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_A   = 5'd1,  ST_B0  = 5'd2,  ST_MUL = 5'd3,
                         ST_ACC  = 5'd4,  ST_SIG = 5'd5,  ST_SMUL = 5'd6, ST_SOUT = 5'd7,
                         ST_G    = 5'd8,  ST_G2  = 5'd9,  ST_D   = 5'd10, ST_T1  = 5'd11,
                         ST_T2   = 5'd12, ST_T3  = 5'd13, ST_B1  = 5'd14, ST_B2  = 5'd15,
                         ST_DONE = 5'd16;

  typedef logic signed [15:0] tab_t [0:SIGMOID_ENTRIES];

  // shift-subtract quotient, only used while the table is elaborated
  function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= dvs) begin
        r    = r - dvs;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series for exp(-8/E), then 1/(1+exp(-k*8/E)) at every other point
  function automatic tab_t build_tab();
    tab_t        t;
    logic [63:0] term, b, p, den, sv;
    term = 64'd1 << 30;
    b    = 64'd1 << 30;
    p    = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = cdiv((term * G_Q30) >> 30, 64'(k));
      if ((k & 1) != 0) b = b - term;
      else b = b + term;
    end
    for (int m = 0; m <= SIGMOID_ENTRIES; m++) begin
      if (((m ^ SIGMOID_ENTRIES) & 1) == 0) begin
        den = (64'd1 << 30) + p;
        sv  = cdiv((64'd1 << 42) + (den >> 1), den);
        t[(SIGMOID_ENTRIES + m) / 2] = 16'(sv);
        t[(SIGMOID_ENTRIES - m) / 2] = 16'(64'(ONE_Q12) - sv);
      end
      p = (p * b + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam tab_t SIG_TAB = build_tab();

  // weight store
  logic signed [15:0] wmem [0:MAX_INPUTS];
  logic [MAX_INPUTS:0] wvalid;
  logic signed [15:0]  rdata;
  logic                rvalid;
  logic [IW-1:0]       raddr;
  logic                we;
  logic [IW-1:0]       waddr;
  logic signed [15:0]  wdata;
  logic signed [15:0]  w;

  logic [4:0]          state, state_next;
  logic [IW-1:0]       pos;
  logic                clip_flag;
  logic signed [39:0]  acc;
  logic signed [15:0]  delta;
  item_t               it;

  logic signed [30:0]  ma;
  logic signed [17:0]  mb;
  logic signed [48:0]  prod;

  logic signed [15:0]  lo_r, hi_r;
  logic [15:0]         frac_r;
  logic signed [15:0]  res_val;
  logic                res_kind;

  // effective count and position decode
  logic [IW-1:0] n, slot;
  logic          pos0, last_el;
  logic [7:0]    ic8;

  always_comb begin
    ic8 = {3'b0, cfg.ic};
    if (cfg.ic == 5'd0) n = IW'(1);
    else if (ic8 > 8'(MAX_INPUTS)) n = IW'(MAX_INPUTS);
    else n = IW'(ic8);
    slot    = (pos < n) ? pos : n - IW'(1);
    pos0    = (pos == '0);
    last_el = ({1'b0, pos} + (IW+1)'(1)) >= {1'b0, n};
  end

  // sigmoid lookup terms
  logic signed [15:0] s_clip;
  logic               s_ovf;
  logic [15:0]        s_off;
  logic [UW-1:0]      u;
  logic [UW-17:0]     uidx;
  logic [TW-1:0]      tidx;

  always_comb begin
    s_clip = sat16(48'(acc >>> 12));
    s_ovf  = ovf16(48'(acc >>> 12));
    s_off  = {~s_clip[15], s_clip[14:0]};
    u      = UW'(s_off) * UW'(SIGMOID_ENTRIES);
    uidx   = u[UW-1:16];
    tidx   = (uidx >= (UW-16)'(SIGMOID_ENTRIES)) ? TW'(SIGMOID_ENTRIES - 1) : TW'(uidx);
  end

  // weight step and bias step
  logic signed [47:0] wsum;
  logic signed [48:0] bneg;
  always_comb begin
    bneg = -prod;
    if (state == ST_B2) wsum = 48'(w) + 48'(bneg >>> 12);
    else wsum = 48'(w) + 48'(prod >>> 24);
  end

  assign w = rvalid ? rdata : 16'sd0;

  logic out_load;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);
  assign q_pop    = (state == ST_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    raddr      = slot;
    ma         = '0;
    mb         = '0;
    we         = 1'b0;
    waddr      = slot;
    wdata      = sat16(wsum);
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.is_load) begin
            we    = ({3'b0, q_item.widx} <= 8'(n));
            waddr = IW'(q_item.widx);
            wdata = q_item.x;
          end else begin
            state_next = ST_A;
          end
        end
      end
      ST_A: begin
        if (it.is_infer) begin
          raddr      = pos0 ? n : slot;
          state_next = pos0 ? ST_B0 : ST_MUL;
        end else begin
          state_next = pos0 ? ST_G : ST_T1;
        end
      end
      ST_B0:   state_next = ST_MUL;
      ST_MUL: begin
        ma = 31'(it.x);
        mb = 18'(w);
        state_next = ST_ACC;
      end
      ST_ACC:  state_next = last_el ? ST_SIG : ST_IDLE;
      ST_SIG:  state_next = ST_SMUL;
      ST_SMUL: begin
        ma = 31'(hi_r) - 31'(lo_r);
        mb = {2'b0, frac_r};
        state_next = ST_SOUT;
      end
      ST_SOUT: state_next = ST_DONE;
      ST_G: begin
        ma = {18'b0, it.a_c};
        mb = 18'(ONE_Q12) - {5'b0, it.a_c};
        state_next = ST_G2;
      end
      ST_G2: begin
        ma = 31'(prod[48:12]);
        mb = 18'(it.err);
        state_next = ST_D;
      end
      ST_D:    state_next = ST_T1;
      ST_T1: begin
        ma = {18'b0, cfg.lr};
        mb = 18'(it.x);
        state_next = ST_T2;
      end
      ST_T2: begin
        ma = prod[30:0];
        mb = 18'(delta);
        state_next = ST_T3;
      end
      ST_T3: begin
        we         = 1'b1;
        state_next = last_el ? ST_B1 : ST_IDLE;
      end
      ST_B1: begin
        raddr = n;
        ma    = {18'b0, cfg.lr};
        mb    = 18'(delta);
        state_next = ST_B2;
      end
      ST_B2: begin
        we    = 1'b1;
        waddr = n;
        state_next = ST_DONE;
      end
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod  <= ma * mb;
    rdata <= wmem[raddr];
    if (we) wmem[waddr] <= wdata;
    if (q_pop) it <= q_item;
    if (state == ST_SIG) begin
      lo_r   <= SIG_TAB[tidx];
      hi_r   <= SIG_TAB[tidx + TW'(1)];
      frac_r <= u[15:0];
    end
    if (state == ST_SOUT) begin
      res_val  <= lo_r + 16'(prod >>> 16);
      res_kind <= 1'b0;
    end
    if (state == ST_B2) begin
      res_val  <= delta;
      res_kind <= 1'b1;
    end
    if (out_load) begin
      out_value <= res_val;
      out_kind  <= res_kind;
      out_sat   <= clip_flag;
    end
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      clip_flag <= 1'b0;
      acc       <= '0;
      delta     <= '0;
      wvalid    <= '0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= wvalid[raddr];
      if (we) wvalid[waddr] <= 1'b1;
      if (state == ST_B0) acc <= -(40'(w) <<< 12);
      if (state == ST_ACC) acc <= acc + 40'(prod);
      if (state == ST_D) delta <= sat16(48'(prod >>> 12));
      if (q_pop && !q_item.is_load && pos0) clip_flag <= 1'b0;
      if (state == ST_SIG && s_ovf) clip_flag <= 1'b1;
      if (state == ST_D && ovf16(48'(prod >>> 12))) clip_flag <= 1'b1;
      if ((state == ST_T3 || state == ST_B2) && ovf16(wsum)) clip_flag <= 1'b1;
      if ((state == ST_ACC || state == ST_T3) && !last_el) pos <= pos + IW'(1);
      if (out_load) pos <= '0;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (int'(waddr) <= MAX_INPUTS))
    else $error("weight write beyond store");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (pos == '0) && (state == ST_IDLE))
    else $error("position not cleared after result");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside done");

endmodule
